// ----- rtl/core/ackermann_steering_kinematics_macros.svh -----
// ----------------------------------------------------------------------------
// Ackermann steering kinematics assertion macros
// Shared concurrent assertion forms used by the steering pipeline.
// ----------------------------------------------------------------------------
`ifndef ACKERMANN_STEERING_KINEMATICS_MACROS_SVH
`define ACKERMANN_STEERING_KINEMATICS_MACROS_SVH

// Check a property in the same cycle as its trigger.
`define ASK_ASSERT_SAME(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Check a property in the cycle after its trigger.
`define ASK_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ----- rtl/core/ask_pkg.sv -----
// ----------------------------------------------------------------------------
// Ackermann steering kinematics package
// Word types, register codes, pipeline stage numbers and the CORDIC table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ask_pkg;

   // Fixed-point format and CORDIC length
   localparam int ANGLE_FRAC_BITS = 13;
   localparam int CORDIC_STEPS    = 16;
   localparam int ANG_SHIFT       = 30 - ANGLE_FRAC_BITS;

   // Internal widths
   localparam int VEC_XW       = 60;
   localparam int VEC_PRESCALE = 28;
   localparam int ROT_XW       = 33;
   localparam int ZW           = 34;

   localparam logic signed [ZW-1:0] Q30_HALF_PI = ZW'(64'sd1686629713);
   localparam logic signed [ZW-1:0] ANG_HALF    = ZW'(1) <<< (ANG_SHIFT - 1);
   localparam logic signed [ROT_XW-1:0] ROT_X0  = ROT_XW'(1) <<< 30;

   // atan(2^-i) in Q30, truncated toward zero
   localparam logic [31:0] ATAN_Q30 [0:31] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
      32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001,
      32'h00000000, 32'h00000000
   };

   // Wheel rate divider
   localparam int DIV_NUM_W = 25;
   localparam int DIV_DEN_W = 11;
   localparam int QUOT_W    = 24;
   localparam int DIV_LAT   = DIV_NUM_W;

   // Pipeline stage numbers (register stage holding each result)
   localparam int VEC_LAT  = CORDIC_STEPS + 1;
   localparam int ROT_LAT  = CORDIC_STEPS;
   localparam int S_CLAMP  = 1;
   localparam int S_PREP   = 2;
   localparam int S_VEC1   = S_PREP + VEC_LAT;
   localparam int S_STEER  = S_VEC1 + 1;
   localparam int S_ROT    = S_STEER + ROT_LAT;
   localparam int S_MUL    = S_ROT + 1;
   localparam int S_ADD    = S_MUL + 1;
   localparam int S_VEC2   = S_ADD + VEC_LAT;
   localparam int S_OUT    = S_VEC2 + 1;
   localparam int S_DIV    = S_CLAMP + DIV_LAT;

   // Register map
   typedef logic [2:0] reg_index_type;
   localparam reg_index_type REG_MAX_SPEED    = 3'd0;
   localparam reg_index_type REG_MAX_YAW_RATE = 3'd1;
   localparam reg_index_type REG_LOW_SPEED    = 3'd2;
   localparam reg_index_type REG_WHEELBASE    = 3'd3;
   localparam reg_index_type REG_TRACK        = 3'd4;
   localparam reg_index_type REG_MAX_STEER    = 3'd5;
   localparam reg_index_type REG_WHEEL_RADIUS = 3'd6;

   typedef struct packed {
      logic signed [15:0] speed_cmd;
      logic signed [15:0] yaw_cmd;
   } req_word_type;

   typedef struct packed {
      logic signed [14:0] steer_angle;
      logic signed [15:0] left_angle;
      logic signed [15:0] right_angle;
      logic signed [23:0] wheel_rate;
      logic               steer_inhibited;
   } rsp_word_type;

   typedef struct packed {
      logic neg;
      logic inhibit;
      logic steer_en;
   } meta_type;

   // CORDIC angle step as a signed angle
   function automatic logic signed [ZW-1:0] atan_step(input logic [4:0] idx);
      return signed'(ZW'(ATAN_Q30[idx]));
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ask_cordic_vec.sv -----
// ----------------------------------------------------------------------------
// Vectoring CORDIC pipeline
// atan2(y, x) in Q30, one quadrant fold stage and one stage per iteration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ask_cordic_vec (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [ask_pkg::VEC_XW-1:0]  vec_x,
   input  logic signed [ask_pkg::VEC_XW-1:0]  vec_y,
   output logic signed [ask_pkg::ZW-1:0]      vec_z
);

   localparam int N  = ask_pkg::CORDIC_STEPS;
   localparam int XW = ask_pkg::VEC_XW;
   localparam int ZW = ask_pkg::ZW;

   logic signed [XW-1:0] x_ff [0:N];
   logic signed [XW-1:0] y_ff [0:N];
   logic signed [ZW-1:0] z_ff [0:N];
   logic                 zero_ff [0:N];
   logic signed [XW-1:0] x_in [0:N];
   logic signed [XW-1:0] y_in [0:N];
   logic signed [ZW-1:0] z_in [0:N];
   logic                 zero_in [0:N];

   // Fold the left half plane onto the right, then iterate
   always_comb begin
      x_in[0]    = vec_x;
      y_in[0]    = vec_y;
      z_in[0]    = '0;
      zero_in[0] = (vec_x == '0) && (vec_y == '0);
      if (vec_x[XW-1]) begin
         if (!vec_y[XW-1]) begin
            x_in[0] = vec_y;
            y_in[0] = -vec_x;
            z_in[0] = ask_pkg::Q30_HALF_PI;
         end else begin
            x_in[0] = -vec_y;
            y_in[0] = vec_x;
            z_in[0] = -ask_pkg::Q30_HALF_PI;
         end
      end
      for (int i = 0; i < N; i++) begin
         zero_in[i+1] = zero_ff[i];
         if (!y_ff[i][XW-1]) begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + ask_pkg::atan_step(5'(i));
         end else begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - ask_pkg::atan_step(5'(i));
         end
      end
   end

   // Advance all stages together
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= N; i++) begin
            x_ff[i]    <= x_in[i];
            y_ff[i]    <= y_in[i];
            z_ff[i]    <= z_in[i];
            zero_ff[i] <= zero_in[i];
         end
      end
   end

   assign vec_z = zero_ff[N] ? '0 : z_ff[N];

endmodule

`default_nettype wire

// ----- rtl/core/ask_cordic_rot.sv -----
// ----------------------------------------------------------------------------
// Rotation CORDIC pipeline
// Gain-scaled cos and sin of a Q30 angle, one stage per iteration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ask_cordic_rot (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [ask_pkg::ZW-1:0]      rot_z,
   output logic signed [ask_pkg::ROT_XW-1:0]  rot_c,
   output logic signed [ask_pkg::ROT_XW-1:0]  rot_s
);

   localparam int N  = ask_pkg::CORDIC_STEPS;
   localparam int XW = ask_pkg::ROT_XW;
   localparam int ZW = ask_pkg::ZW;

   logic signed [XW-1:0] x_ff [0:N-1];
   logic signed [XW-1:0] y_ff [0:N-1];
   logic signed [ZW-1:0] z_ff [0:N-1];
   logic signed [XW-1:0] x_in [0:N-1];
   logic signed [XW-1:0] y_in [0:N-1];
   logic signed [ZW-1:0] z_in [0:N-1];
   logic signed [XW-1:0] x_p [0:N-1];
   logic signed [XW-1:0] y_p [0:N-1];
   logic signed [ZW-1:0] z_p [0:N-1];

   // Rotate toward zero residual angle
   always_comb begin
      x_p[0] = ask_pkg::ROT_X0;
      y_p[0] = '0;
      z_p[0] = rot_z;
      for (int i = 1; i < N; i++) begin
         x_p[i] = x_ff[i-1];
         y_p[i] = y_ff[i-1];
         z_p[i] = z_ff[i-1];
      end
      for (int i = 0; i < N; i++) begin
         if (!z_p[i][ZW-1]) begin
            x_in[i] = x_p[i] - (y_p[i] >>> i);
            y_in[i] = y_p[i] + (x_p[i] >>> i);
            z_in[i] = z_p[i] - ask_pkg::atan_step(5'(i));
         end else begin
            x_in[i] = x_p[i] + (y_p[i] >>> i);
            y_in[i] = y_p[i] - (x_p[i] >>> i);
            z_in[i] = z_p[i] + ask_pkg::atan_step(5'(i));
         end
      end
   end

   // Advance all stages together
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < N; i++) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            z_ff[i] <= z_in[i];
         end
      end
   end

   assign rot_c = x_ff[N-1];
   assign rot_s = y_ff[N-1];

endmodule

`default_nettype wire

// ----- rtl/core/ask_rate_div.sv -----
// ----------------------------------------------------------------------------
// Wheel rate divider
// Restoring division, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ask_rate_div (
   input  logic                              clock,
   input  logic                              en,
   input  logic [ask_pkg::DIV_NUM_W-1:0]     div_num,
   input  logic [ask_pkg::DIV_DEN_W-1:0]     div_den,
   output logic [ask_pkg::QUOT_W-1:0]        div_quot
);

   localparam int NW  = ask_pkg::DIV_NUM_W;
   localparam int DW  = ask_pkg::DIV_DEN_W;
   localparam int LAT = ask_pkg::DIV_LAT;

   logic [DW-1:0] rem_ff  [0:LAT-1];
   logic [NW-1:0] num_ff  [0:LAT-1];
   logic [NW-1:0] quot_ff [0:LAT-1];
   logic [DW-1:0] rem_in  [0:LAT-1];
   logic [NW-1:0] num_in  [0:LAT-1];
   logic [NW-1:0] quot_in [0:LAT-1];
   logic [DW-1:0] rem_p   [0:LAT-1];
   logic [NW-1:0] num_p   [0:LAT-1];
   logic [NW-1:0] quot_p  [0:LAT-1];
   logic [DW:0]   trial   [0:LAT-1];

   // Bring down one numerator bit and try a subtract
   always_comb begin
      rem_p[0]  = '0;
      num_p[0]  = div_num;
      quot_p[0] = '0;
      for (int j = 1; j < LAT; j++) begin
         rem_p[j]  = rem_ff[j-1];
         num_p[j]  = num_ff[j-1];
         quot_p[j] = quot_ff[j-1];
      end
      for (int j = 0; j < LAT; j++) begin
         trial[j]  = {rem_p[j], num_p[j][NW-1]};
         num_in[j] = num_p[j] << 1;
         if (trial[j] >= {1'b0, div_den}) begin
            rem_in[j]  = DW'(trial[j] - {1'b0, div_den});
            quot_in[j] = {quot_p[j][NW-2:0], 1'b1};
         end else begin
            rem_in[j]  = trial[j][DW-1:0];
            quot_in[j] = {quot_p[j][NW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < LAT; j++) begin
            rem_ff[j]  <= rem_in[j];
            num_ff[j]  <= num_in[j];
            quot_ff[j] <= quot_in[j];
         end
      end
   end

   assign div_quot = quot_ff[LAT-1][ask_pkg::QUOT_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/ackermann_steering_kinematics.sv -----
// Ackermann steering kinematics: takes one command word per cycle while the
// result word is not stalled (speed in mm/s, yaw rate in mrad/s) and returns
// one result word per command, in order. The path is fully unrolled: a
// 17-stage vectoring CORDIC for the central steer angle, a 16-stage rotation
// CORDIC for its sine and cosine, a multiply and an add stage, two parallel
// 17-stage vectoring CORDICs for the wheel angles, and a 25-stage divider
// for the wheel rate running alongside. Every stage advances together, so a
// stalled result word freezes the whole pipeline and holds off the input.
// There is no clearing pass after reset. Write the registers only while no
// command is in flight.
// ----------------------------------------------------------------------------
// Ackermann steering kinematics top level
// Command clamp, steer angle, wheel angles and wheel rate pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ackermann_steering_kinematics_macros.svh"

module ackermann_steering_kinematics (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ask_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ask_pkg::rsp_word_type rsp_word,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [4:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int VW = ask_pkg::VEC_XW;
   localparam int RW = ask_pkg::ROT_XW;
   localparam int ZW = ask_pkg::ZW;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [14:0] max_speed_ff, max_yaw_ff, low_speed_ff;
   logic [12:0] wheelbase_ff, track_ff;
   logic [13:0] max_steer_ff;
   logic [9:0]  radius_ff;
   logic        csr_write;
   ask_pkg::reg_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff <= 15'd2000;
         max_yaw_ff   <= 15'd2000;
         low_speed_ff <= 15'd10;
         wheelbase_ff <= 13'd300;
         track_ff     <= 13'd250;
         max_steer_ff <= 14'd4096;
         radius_ff    <= 10'd50;
      end else if (csr_write) begin
         case (csr_index)
            ask_pkg::REG_MAX_SPEED:    max_speed_ff <= csr_pwdata[14:0];
            ask_pkg::REG_MAX_YAW_RATE: max_yaw_ff   <= csr_pwdata[14:0];
            ask_pkg::REG_LOW_SPEED:    low_speed_ff <= csr_pwdata[14:0];
            ask_pkg::REG_WHEELBASE:    wheelbase_ff <= csr_pwdata[12:0];
            ask_pkg::REG_TRACK:        track_ff     <= csr_pwdata[12:0];
            ask_pkg::REG_MAX_STEER:    max_steer_ff <= csr_pwdata[13:0];
            ask_pkg::REG_WHEEL_RADIUS: radius_ff    <= csr_pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         ask_pkg::REG_MAX_SPEED:    csr_prdata = 32'(max_speed_ff);
         ask_pkg::REG_MAX_YAW_RATE: csr_prdata = 32'(max_yaw_ff);
         ask_pkg::REG_LOW_SPEED:    csr_prdata = 32'(low_speed_ff);
         ask_pkg::REG_WHEELBASE:    csr_prdata = 32'(wheelbase_ff);
         ask_pkg::REG_TRACK:        csr_prdata = 32'(track_ff);
         ask_pkg::REG_MAX_STEER:    csr_prdata = 32'(max_steer_ff);
         ask_pkg::REG_WHEEL_RADIUS: csr_prdata = 32'(radius_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Pipeline control: every stage advances unless the output word stalls
   // ---------------------------------------------------------------------
   logic v_ff [ask_pkg::S_CLAMP:ask_pkg::S_OUT];
   logic adv;

   assign adv       = !(v_ff[ask_pkg::S_OUT] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = v_ff[ask_pkg::S_OUT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = ask_pkg::S_CLAMP; i <= ask_pkg::S_OUT; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         v_ff[ask_pkg::S_CLAMP] <= req_valid;
         for (int i = ask_pkg::S_CLAMP + 1; i <= ask_pkg::S_OUT; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Clamp stage: limit both commands, fold yaw sign for reverse motion
   // ---------------------------------------------------------------------
   logic signed [16:0] spd_x, yaw_x, spd_lim, yaw_lim, vx_c, wz_c;
   logic signed [15:0] wz_in, wz_ff;
   logic [14:0]        ax_in, ax_ff;
   logic               neg_in, neg_ff, inh_in, inh_ff;

   always_comb begin
      spd_x   = 17'(req_word.speed_cmd);
      yaw_x   = 17'(req_word.yaw_cmd);
      spd_lim = signed'({2'b00, max_speed_ff});
      yaw_lim = signed'({2'b00, max_yaw_ff});
      if (spd_x > spd_lim)       vx_c = spd_lim;
      else if (spd_x < -spd_lim) vx_c = -spd_lim;
      else                       vx_c = spd_x;
      if (yaw_x > yaw_lim)       wz_c = yaw_lim;
      else if (yaw_x < -yaw_lim) wz_c = -yaw_lim;
      else                       wz_c = yaw_x;
      neg_in = vx_c[16];
      ax_in  = neg_in ? 15'(-vx_c) : vx_c[14:0];
      inh_in = ax_in < low_speed_ff;
      wz_in  = neg_in ? 16'(-wz_c) : wz_c[15:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         wz_ff  <= wz_in;
         ax_ff  <= ax_in;
         neg_ff <= neg_in;
         inh_ff <= inh_in;
      end
   end

   // ---------------------------------------------------------------------
   // Prep stage: scale the ratio operands for the steer CORDIC
   // ---------------------------------------------------------------------
   logic [24:0]          ax_k;
   logic signed [29:0]   yl;
   logic signed [VW-1:0] x0_in, y0_in, x0_ff, y0_ff;
   ask_pkg::meta_type    meta_in;
   ask_pkg::meta_type    meta_ff [ask_pkg::S_PREP:ask_pkg::S_OUT-1];

   always_comb begin
      ax_k             = 25'(ax_ff) * 25'd1000;
      yl               = 30'(wz_ff) * signed'(30'(wheelbase_ff));
      x0_in            = VW'(ax_k) << ask_pkg::VEC_PRESCALE;
      y0_in            = VW'(yl) <<< ask_pkg::VEC_PRESCALE;
      meta_in.neg      = neg_ff;
      meta_in.inhibit  = inh_ff;
      meta_in.steer_en = !inh_ff && (wz_ff != '0) && (wheelbase_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x0_ff                   <= x0_in;
         y0_ff                   <= y0_in;
         meta_ff[ask_pkg::S_PREP] <= meta_in;
         for (int i = ask_pkg::S_PREP + 1; i < ask_pkg::S_OUT; i++) begin
            meta_ff[i] <= meta_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Central steer angle
   // ---------------------------------------------------------------------
   logic signed [ZW-1:0] steer_z, steer_r;
   logic signed [17:0]   steer_q, steer_m, steer_k;
   logic signed [14:0]   steer_in;
   logic signed [14:0]   steer_ff [ask_pkg::S_STEER:ask_pkg::S_OUT-1];

   ask_cordic_vec u_vec_steer (
      .clock (clock),
      .en    (adv),
      .vec_x (x0_ff),
      .vec_y (y0_ff),
      .vec_z (steer_z)
   );

   // Round to the angle format and clamp
   always_comb begin
      steer_r = (steer_z + ask_pkg::ANG_HALF) >>> ask_pkg::ANG_SHIFT;
      steer_q = steer_r[17:0];
      steer_m = signed'({4'b0000, max_steer_ff});
      if (steer_q > steer_m)       steer_k = steer_m;
      else if (steer_q < -steer_m) steer_k = -steer_m;
      else                         steer_k = steer_q;
      steer_in = meta_ff[ask_pkg::S_VEC1].steer_en ? steer_k[14:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         steer_ff[ask_pkg::S_STEER] <= steer_in;
         for (int i = ask_pkg::S_STEER + 1; i < ask_pkg::S_OUT; i++) begin
            steer_ff[i] <= steer_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sine and cosine of the steer angle
   // ---------------------------------------------------------------------
   logic signed [RW-1:0] rot_c, rot_s;
   logic signed [ZW-1:0] rot_z;

   assign rot_z = ZW'(steer_ff[ask_pkg::S_STEER]) <<< ask_pkg::ANG_SHIFT;

   ask_cordic_rot u_rot (
      .clock (clock),
      .en    (adv),
      .rot_z (rot_z),
      .rot_c (rot_c),
      .rot_s (rot_s)
   );

   // ---------------------------------------------------------------------
   // Multiply then add: wheel angle numerator and denominators
   // ---------------------------------------------------------------------
   logic signed [14:0]   two_l, trk;
   logic signed [47:0]   plc_in, pls_in, pws_in, plc_ff, pls_ff, pws_ff;
   logic signed [VW-1:0] num_ff, denl_ff, denr_ff;

   assign two_l  = signed'({1'b0, wheelbase_ff, 1'b0});
   assign trk    = signed'({2'b00, track_ff});
   assign plc_in = 48'(rot_c) * 48'(two_l);
   assign pls_in = 48'(rot_s) * 48'(two_l);
   assign pws_in = 48'(rot_s) * 48'(trk);

   always_ff @(posedge clock) begin
      if (adv) begin
         plc_ff  <= plc_in;
         pls_ff  <= pls_in;
         pws_ff  <= pws_in;
         num_ff  <= VW'(pls_ff);
         denl_ff <= VW'(plc_ff) - VW'(pws_ff);
         denr_ff <= VW'(plc_ff) + VW'(pws_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Left and right wheel angles
   // ---------------------------------------------------------------------
   logic signed [ZW-1:0] left_z, right_z, left_r, right_r;

   ask_cordic_vec u_vec_left (
      .clock (clock),
      .en    (adv),
      .vec_x (denl_ff),
      .vec_y (num_ff),
      .vec_z (left_z)
   );

   ask_cordic_vec u_vec_right (
      .clock (clock),
      .en    (adv),
      .vec_x (denr_ff),
      .vec_y (num_ff),
      .vec_z (right_z)
   );

   // ---------------------------------------------------------------------
   // Wheel rate: round(|speed| * 256 / radius)
   // ---------------------------------------------------------------------
   logic [ask_pkg::DIV_NUM_W-1:0] div_num;
   logic [ask_pkg::DIV_DEN_W-1:0] div_den;
   logic [ask_pkg::QUOT_W-1:0]    div_quot;
   logic [ask_pkg::QUOT_W-1:0]    quot_ff [ask_pkg::S_DIV+1:ask_pkg::S_OUT-1];

   assign div_num = ask_pkg::DIV_NUM_W'({ax_ff, 9'd0}) + ask_pkg::DIV_NUM_W'(radius_ff);
   assign div_den = {radius_ff, 1'b0};

   ask_rate_div u_div (
      .clock    (clock),
      .en       (adv),
      .div_num  (div_num),
      .div_den  (div_den),
      .div_quot (div_quot)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         quot_ff[ask_pkg::S_DIV+1] <= div_quot;
         for (int i = ask_pkg::S_DIV + 2; i < ask_pkg::S_OUT; i++) begin
            quot_ff[i] <= quot_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Output stage: round wheel angles, sign and saturate the wheel rate
   // ---------------------------------------------------------------------
   ask_pkg::rsp_word_type rsp_in, rsp_ff;
   ask_pkg::meta_type     meta_last;
   logic signed [14:0]    steer_last;
   logic [23:0]           mag;

   always_comb begin
      meta_last  = meta_ff[ask_pkg::S_OUT-1];
      steer_last = steer_ff[ask_pkg::S_OUT-1];
      left_r     = (left_z + ask_pkg::ANG_HALF) >>> ask_pkg::ANG_SHIFT;
      right_r    = (right_z + ask_pkg::ANG_HALF) >>> ask_pkg::ANG_SHIFT;
      mag        = quot_ff[ask_pkg::S_OUT-1][23] ? 24'h7FFFFF
                                                 : quot_ff[ask_pkg::S_OUT-1];
      rsp_in.steer_angle     = steer_last;
      rsp_in.left_angle      = (steer_last != '0) ? left_r[15:0] : '0;
      rsp_in.right_angle     = (steer_last != '0) ? right_r[15:0] : '0;
      rsp_in.steer_inhibited = meta_last.inhibit;
      if (radius_ff == '0)    rsp_in.wheel_rate = '0;
      else if (meta_last.neg) rsp_in.wheel_rate = -signed'(mag);
      else                    rsp_in.wheel_rate = signed'(mag);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_word = rsp_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   logic signed [15:0] steer_chk, steer_lim;

   assign steer_chk = 16'(rsp_word.steer_angle);
   assign steer_lim = signed'({2'b00, max_steer_ff});

   `ASK_ASSERT_SAME(a_inhibit_zero, clock, reset,
      rsp_valid && rsp_word.steer_inhibited,
      rsp_word.steer_angle == '0 && rsp_word.left_angle == '0 && rsp_word.right_angle == '0,
      "inhibited word carries a nonzero angle")
   `ASK_ASSERT_SAME(a_steer_limit, clock, reset, rsp_valid,
      steer_chk <= steer_lim && steer_chk >= -steer_lim,
      "steer angle beyond its clamp")
   `ASK_ASSERT_SAME(a_radius_zero, clock, reset, rsp_valid && radius_ff == '0,
      rsp_word.wheel_rate == '0, "wheel rate nonzero with zero radius")
   `ASK_ASSERT_NEXT(a_enter, clock, reset, req_valid && !req_stall,
      v_ff[ask_pkg::S_CLAMP], "accepted word did not enter the pipeline")

endmodule

`default_nettype wire
